// File: rtl/wcg_pkg.sv
`timescale 1ns / 1ps

package wcg_pkg;

  // Width of the queue, container and size fields
  localparam int unsigned QueueW     = 24;
  localparam int unsigned ContainerW = 16;
  localparam int unsigned SizeW      = 32;
  localparam int unsigned PendingW   = 32;

  // Gate phases; unused codes behave as idle
  typedef enum logic [2:0] {
    PhIdle     = 3'd0,
    PhWaitB    = 3'd1,
    PhReady    = 3'd2,
    PhMemWait  = 3'd3,
    PhMemBWait = 3'd4
  } phase_e;

  // One input request: B beat, done offer and transfer offer of one gate step
  typedef struct packed {
    logic                  b_valid;
    logic                  done_valid;
    logic                  expect_done;
    logic                  send_done;
    logic                  mem_valid;
    logic [QueueW-1:0]     queue_id;
    logic [ContainerW-1:0] container_id;
    logic [SizeW-1:0]      transfer_size;
    logic                  needs_send;
    logic                  last_flag;
    logic                  skippable;
  } in_req_t;

  // One result: accept flags and the forwarded transfer
  typedef struct packed {
    logic                  done_accepted;
    logic                  mem_accepted;
    logic                  fwd_valid;
    logic [QueueW-1:0]     fwd_queue;
    logic [ContainerW-1:0] fwd_container;
    logic [SizeW-1:0]      fwd_size;
    logic                  fwd_last;
  } out_rsp_t;

  // Decisions taken in one step, passed from the decide to the output logic
  typedef struct packed {
    logic done_acc;
    logic mem_acc;
    logic emit_in;
    logic emit_held;
  } step_ctl_t;

endpackage

// File: rtl/wcg_core.sv
`timescale 1ns / 1ps

module wcg_core #(
  parameter int unsigned CONTAINER_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  wcg_pkg::in_req_t  req_i,
  output wcg_pkg::out_rsp_t rsp_o
);

  // Stored container bits: the forwarded field is never wider than the port
  localparam int unsigned HeldCntW =
    (CONTAINER_WIDTH > wcg_pkg::ContainerW) ? wcg_pkg::ContainerW : CONTAINER_WIDTH;

  wcg_pkg::phase_e                     phase_q, phase_d;
  logic [wcg_pkg::PendingW-1:0]        pending_q, pending_d;
  logic                                perm_q, perm_d;
  logic [wcg_pkg::QueueW-1:0]          held_queue_q;
  logic [HeldCntW-1:0]                 held_container_q;
  logic [wcg_pkg::SizeW-1:0]           held_size_q;
  logic                                held_needs_send_q;
  logic                                held_last_q;

  wcg_pkg::step_ctl_t ctl;
  logic               b_avail;
  logic               dec;
  logic               hold_load;

  assign b_avail = req_i.b_valid || (pending_q != '0);

  // Decide next phase, counter use and what to emit
  always_comb begin
    phase_d   = phase_q;
    perm_d    = perm_q;
    dec       = 1'b0;
    hold_load = 1'b0;
    ctl       = '0;
    unique case (phase_q)
      wcg_pkg::PhWaitB: begin
        if (b_avail) begin
          dec     = 1'b1;
          phase_d = perm_q ? wcg_pkg::PhReady : wcg_pkg::PhIdle;
        end else if (req_i.mem_valid) begin
          ctl.mem_acc = 1'b1;
          hold_load   = 1'b1;
          if (req_i.skippable) begin
            ctl.emit_in = 1'b1;
          end else begin
            phase_d = wcg_pkg::PhMemBWait;
          end
        end
      end
      wcg_pkg::PhReady: begin
        if (req_i.mem_valid) begin
          ctl.mem_acc = 1'b1;
          ctl.emit_in = 1'b1;
          if (!req_i.skippable) begin
            phase_d = wcg_pkg::PhIdle;
          end
        end
      end
      wcg_pkg::PhMemWait: begin
        if (req_i.done_valid) begin
          ctl.done_acc = 1'b1;
          perm_d       = req_i.send_done;
          if (!b_avail && req_i.expect_done) begin
            phase_d = wcg_pkg::PhMemBWait;
          end else begin
            if (req_i.send_done) begin
              ctl.emit_held = 1'b1;
              phase_d       = wcg_pkg::PhIdle;
            end
            dec = req_i.expect_done;
          end
        end
      end
      wcg_pkg::PhMemBWait: begin
        if (b_avail) begin
          dec = 1'b1;
          if (perm_q) begin
            ctl.emit_held = 1'b1;
            phase_d       = wcg_pkg::PhIdle;
          end else begin
            phase_d = wcg_pkg::PhMemWait;
          end
        end
      end
      default: begin
        phase_d = wcg_pkg::PhIdle;
        if (req_i.done_valid) begin
          ctl.done_acc = 1'b1;
          perm_d       = req_i.send_done;
          if (!b_avail && req_i.expect_done) begin
            phase_d = wcg_pkg::PhWaitB;
          end else begin
            phase_d = req_i.send_done ? wcg_pkg::PhReady : wcg_pkg::PhIdle;
            dec     = req_i.expect_done;
          end
        end else if (req_i.mem_valid) begin
          ctl.mem_acc = 1'b1;
          hold_load   = 1'b1;
          if (req_i.skippable) begin
            ctl.emit_in = 1'b1;
          end else begin
            phase_d = wcg_pkg::PhMemWait;
          end
        end
      end
    endcase
  end

  // Count B beats not yet matched by a done, wrapping at the counter width
  always_comb begin
    pending_d = pending_q;
    if (req_i.b_valid && !dec) begin
      pending_d = pending_q + wcg_pkg::PendingW'(1);
    end else if (!req_i.b_valid && dec) begin
      pending_d = pending_q - wcg_pkg::PendingW'(1);
    end
  end

  // Build the result; fields stay zero when nothing is forwarded
  always_comb begin
    rsp_o               = '0;
    rsp_o.done_accepted = ctl.done_acc;
    rsp_o.mem_accepted  = ctl.mem_acc;
    if (ctl.emit_in && req_i.needs_send) begin
      rsp_o.fwd_valid     = 1'b1;
      rsp_o.fwd_queue     = req_i.queue_id;
      rsp_o.fwd_container = wcg_pkg::ContainerW'(req_i.container_id[HeldCntW-1:0]);
      rsp_o.fwd_size      = req_i.transfer_size;
      rsp_o.fwd_last      = req_i.last_flag;
    end else if (ctl.emit_held && held_needs_send_q) begin
      rsp_o.fwd_valid     = 1'b1;
      rsp_o.fwd_queue     = held_queue_q;
      rsp_o.fwd_container = wcg_pkg::ContainerW'(held_container_q);
      rsp_o.fwd_size      = held_size_q;
      rsp_o.fwd_last      = held_last_q;
    end
  end

  // Advance control state once per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= wcg_pkg::PhIdle;
      pending_q         <= '0;
      perm_q            <= 1'b0;
      held_needs_send_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      perm_q    <= perm_d;
      if (hold_load) begin
        held_needs_send_q <= req_i.needs_send;
      end
    end
  end

  // Hold the parked transfer payload
  always_ff @(posedge clk_i) begin
    if (step_i && hold_load) begin
      held_queue_q     <= req_i.queue_id;
      held_container_q <= req_i.container_id[HeldCntW-1:0];
      held_size_q      <= req_i.transfer_size;
      held_last_q      <= req_i.last_flag;
    end
  end

endmodule

// File: rtl/write_completion_gate_unit.sv
`timescale 1ns / 1ps

// Write completion gate. Each request carries the inputs of one gate step: an
// optional B beat, an optional done offer and an optional transfer offer; each
// request produces exactly one result with the accept flags and an optional
// forwarded transfer. A request passes an input register, one step of the gate
// state machine and B counter, and a result register. One request is taken every
// cycle as long as results are taken. When the result register is full and not
// taken, the input register holds its request and ready drops until the result
// moves on.
module write_completion_gate_unit #(
  parameter int unsigned CONTAINER_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wcg_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wcg_pkg::out_rsp_t out_rsp_o
);

  logic              s1_valid_q, s1_valid_d;
  wcg_pkg::in_req_t  s1_req_q;
  logic              out_valid_q, out_valid_d;
  wcg_pkg::out_rsp_t out_rsp_q;
  wcg_pkg::out_rsp_t step_rsp;
  logic              advance;

  // Move the held request into the gate when the result slot frees up
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  wcg_core #(
    .CONTAINER_WIDTH(CONTAINER_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .req_i (s1_req_q),
    .rsp_o (step_rsp)
  );

  // Valid bits of the input and result registers
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture request and result payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= in_req_i;
    end
    if (advance) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: tb/write_completion_gate_unit_tb.sv
`timescale 1ns / 1ps

module write_completion_gate_unit_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffLen = 80;
  localparam int unsigned RandPerPhase = 275;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  wcg_pkg::in_req_t   in_req = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  wcg_pkg::out_rsp_t  out_rsp;

  // Requests waiting to be offered and results the gate must still produce
  wcg_pkg::in_req_t   request_q[$];
  wcg_pkg::out_rsp_t  gate_result_q[$];

  // Idle and stall rates of the current phase, in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Long receiver hold-off, asked by the stimulus and served by the receiver
  int unsigned hold_off_asked = 0;
  int unsigned hold_off_served = 0;
  int unsigned hold_off_left = 0;

  int unsigned offered_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned fwd_cnt = 0;
  int unsigned done_cnt = 0;
  int unsigned mem_cnt = 0;

  // Shadow of the gate state
  wcg_pkg::phase_e                gate_phase = wcg_pkg::PhIdle;
  logic [wcg_pkg::PendingW-1:0]   pending_b = '0;
  logic                           held_permit = 1'b0;
  logic [wcg_pkg::QueueW-1:0]     held_queue = '0;
  logic [wcg_pkg::ContainerW-1:0] held_container = '0;
  logic [wcg_pkg::SizeW-1:0]      held_size = '0;
  logic                           held_needs_send = 1'b0;
  logic                           held_last = 1'b0;

  write_completion_gate_unit #(
    .CONTAINER_WIDTH(wcg_pkg::ContainerW)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  always #5 clk = ~clk;

  // Forward the offered transfer when it must be sent
  function automatic void pass_through(input wcg_pkg::in_req_t r,
                                       inout wcg_pkg::out_rsp_t o);
    if (r.needs_send) begin
      o.fwd_valid     = 1'b1;
      o.fwd_queue     = r.queue_id;
      o.fwd_container = r.container_id;
      o.fwd_size      = r.transfer_size;
      o.fwd_last      = r.last_flag;
    end
  endfunction

  // Forward the held transfer when it must be sent
  function automatic void release_held(inout wcg_pkg::out_rsp_t o);
    if (held_needs_send) begin
      o.fwd_valid     = 1'b1;
      o.fwd_queue     = held_queue;
      o.fwd_container = held_container;
      o.fwd_size      = held_size;
      o.fwd_last      = held_last;
    end
  endfunction

  function automatic void capture_held(input wcg_pkg::in_req_t r);
    held_queue      = r.queue_id;
    held_container  = r.container_id;
    held_size       = r.transfer_size;
    held_needs_send = r.needs_send;
    held_last       = r.last_flag;
  endfunction

  // Advance the shadow gate by one request and return its result
  function automatic wcg_pkg::out_rsp_t gate_decide(input wcg_pkg::in_req_t r);
    wcg_pkg::out_rsp_t o;
    logic              b_avail;
    logic              take_b;
    o = '0;
    take_b = 1'b0;
    b_avail = r.b_valid || (pending_b != '0);
    case (gate_phase)
      wcg_pkg::PhWaitB: begin
        if (b_avail) begin
          take_b = 1'b1;
          gate_phase = held_permit ? wcg_pkg::PhReady : wcg_pkg::PhIdle;
        end else if (r.mem_valid) begin
          o.mem_accepted = 1'b1;
          capture_held(r);
          if (r.skippable) pass_through(r, o);
          else gate_phase = wcg_pkg::PhMemBWait;
        end
      end
      wcg_pkg::PhReady: begin
        if (r.mem_valid) begin
          o.mem_accepted = 1'b1;
          pass_through(r, o);
          if (!r.skippable) gate_phase = wcg_pkg::PhIdle;
        end
      end
      wcg_pkg::PhMemWait: begin
        if (r.done_valid) begin
          o.done_accepted = 1'b1;
          held_permit = r.send_done;
          if (!b_avail && r.expect_done) begin
            gate_phase = wcg_pkg::PhMemBWait;
          end else begin
            if (r.send_done) begin
              release_held(o);
              gate_phase = wcg_pkg::PhIdle;
            end
            take_b = r.expect_done;
          end
        end
      end
      wcg_pkg::PhMemBWait: begin
        if (b_avail) begin
          take_b = 1'b1;
          if (held_permit) begin
            release_held(o);
            gate_phase = wcg_pkg::PhIdle;
          end else begin
            gate_phase = wcg_pkg::PhMemWait;
          end
        end
      end
      default: begin
        gate_phase = wcg_pkg::PhIdle;
        if (r.done_valid) begin
          o.done_accepted = 1'b1;
          held_permit = r.send_done;
          if (!b_avail && r.expect_done) begin
            gate_phase = wcg_pkg::PhWaitB;
          end else begin
            gate_phase = r.send_done ? wcg_pkg::PhReady : wcg_pkg::PhIdle;
            take_b = r.expect_done;
          end
        end else if (r.mem_valid) begin
          o.mem_accepted = 1'b1;
          capture_held(r);
          if (r.skippable) pass_through(r, o);
          else gate_phase = wcg_pkg::PhMemWait;
        end
      end
    endcase
    if (r.b_valid && !take_b) pending_b = pending_b + wcg_pkg::PendingW'(1);
    else if (!r.b_valid && take_b) pending_b = pending_b - wcg_pkg::PendingW'(1);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR result %0d: %s got %0h want %0h", result_cnt, what, got, want);
    error_cnt++;
  endtask

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Build a request with the given control bits and random transfer fields
  function automatic wcg_pkg::in_req_t make_req(input bit b, input bit dv, input bit ex,
                                                input bit sd, input bit mv, input bit skip);
    wcg_pkg::in_req_t r;
    r.b_valid       = b;
    r.done_valid    = dv;
    r.expect_done   = ex;
    r.send_done     = sd;
    r.mem_valid     = mv;
    r.queue_id      = wcg_pkg::QueueW'($urandom());
    r.container_id  = wcg_pkg::ContainerW'($urandom());
    r.transfer_size = wcg_pkg::SizeW'($urandom());
    r.needs_send    = ($urandom_range(0, 3) != 0);
    r.last_flag     = rand_bit();
    r.skippable     = skip;
    return r;
  endfunction

  task automatic add_req(input wcg_pkg::in_req_t r);
    request_q.push_back(r);
    queued_cnt++;
  endtask

  // Directed request with fixed payload: all zeros or all ones
  task automatic add_fixed(input bit b, input bit dv, input bit ex, input bit sd,
                           input bit mv, input bit ns, input bit skip, input bit ones);
    wcg_pkg::in_req_t r;
    r = make_req(b, dv, ex, sd, mv, skip);
    r.queue_id      = ones ? '1 : '0;
    r.container_id  = ones ? '1 : '0;
    r.transfer_size = ones ? '1 : '0;
    r.last_flag     = ones;
    r.needs_send    = ns;
    add_req(r);
  endtask

  // Push one short sequence: mostly well-formed gate traffic, some noise
  task automatic push_scenario();
    bit s;
    case ($urandom_range(0, 7))
      0, 1: begin
        repeat ($urandom_range(1, 3))
          add_req(make_req(rand_bit(), rand_bit(), rand_bit(), rand_bit(),
                           rand_bit(), rand_bit()));
      end
      2, 7: begin
        // done waits for a B, then permits a transfer
        s = ($urandom_range(0, 3) != 0);
        add_req(make_req(0, 1, 1, s, 0, 0));
        repeat ($urandom_range(0, 2)) add_req(make_req(0, 0, 0, 0, 1, 1));
        add_req(make_req(1, 0, 0, 0, 0, 0));
        add_req(make_req(0, 0, 0, 0, 1, $urandom_range(0, 3) == 0));
      end
      3: begin
        // transfer held until a done and its B arrive
        add_req(make_req(0, 0, 0, 0, 1, 0));
        add_req(make_req(0, 1, rand_bit(), rand_bit(), 0, 0));
        add_req(make_req(1, 0, 0, 0, 0, 0));
        add_req(make_req(0, 1, 0, 1, 0, 0));
      end
      4: begin
        // bank B beats, then spend one
        repeat ($urandom_range(1, 3))
          add_req(make_req(1, 0, 0, 0, rand_bit(), rand_bit()));
        add_req(make_req(0, 1, 1, rand_bit(), rand_bit(), 0));
        add_req(make_req(0, 0, 0, 0, 1, 0));
      end
      5: begin
        // transfer arrives after the done, B comes last
        add_req(make_req(0, 1, 1, 1, 0, 0));
        add_req(make_req(0, 0, 0, 0, 1, 0));
        add_req(make_req(1, rand_bit(), rand_bit(), rand_bit(), rand_bit(), rand_bit()));
      end
      default: begin
        // done and transfer offered together
        add_req(make_req(rand_bit(), 1, rand_bit(), rand_bit(), 1, rand_bit()));
        add_req(make_req(1, 1, 1, rand_bit(), 1, rand_bit()));
      end
    endcase
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || gate_result_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start_cnt;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start_cnt = queued_cnt;
    while (queued_cnt - start_cnt < RandPerPhase) push_scenario();
    wait_drained();
  endtask

  // Offer the next request at the falling edge once the current one is taken
  always @(negedge clk) begin : drive_req
    logic             nxt_valid;
    wcg_pkg::in_req_t nxt_req;
    nxt_valid = in_valid;
    nxt_req = in_req;
    if (accepted_cnt == offered_cnt) begin
      nxt_valid = 1'b0;
      if (rst_n && request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_req = request_q.pop_front();
        nxt_valid = 1'b1;
        offered_cnt++;
      end
    end
    in_valid <= nxt_valid;
    in_req <= nxt_req;
  end

  // Drive result ready: long hold-off when asked, else random stalls
  always @(negedge clk) begin : drive_ready
    logic rdy;
    if (hold_off_served != hold_off_asked) begin
      hold_off_left = HoldOffLen;
      hold_off_served = hold_off_asked;
    end
    if (hold_off_left > 0) begin
      rdy = 1'b0;
      hold_off_left--;
    end else begin
      rdy = ($urandom_range(0, 99) >= recv_stall_pct);
    end
    out_ready <= rdy;
  end

  // Check results against the oldest prediction, then predict taken requests
  always @(posedge clk) begin : watch
    wcg_pkg::out_rsp_t want;
    if (out_valid && out_ready) begin
      if (gate_result_q.size() == 0) begin
        report_mismatch("result with nothing predicted", 32'(out_rsp), 32'd0);
      end else begin
        want = gate_result_q.pop_front();
        if (out_rsp.done_accepted !== want.done_accepted)
          report_mismatch("done_accepted", 32'(out_rsp.done_accepted),
                          32'(want.done_accepted));
        if (out_rsp.mem_accepted !== want.mem_accepted)
          report_mismatch("mem_accepted", 32'(out_rsp.mem_accepted),
                          32'(want.mem_accepted));
        if (out_rsp.fwd_valid !== want.fwd_valid)
          report_mismatch("fwd_valid", 32'(out_rsp.fwd_valid), 32'(want.fwd_valid));
        if (out_rsp.fwd_queue !== want.fwd_queue)
          report_mismatch("fwd_queue", 32'(out_rsp.fwd_queue), 32'(want.fwd_queue));
        if (out_rsp.fwd_container !== want.fwd_container)
          report_mismatch("fwd_container", 32'(out_rsp.fwd_container),
                          32'(want.fwd_container));
        if (out_rsp.fwd_size !== want.fwd_size)
          report_mismatch("fwd_size", out_rsp.fwd_size, want.fwd_size);
        if (out_rsp.fwd_last !== want.fwd_last)
          report_mismatch("fwd_last", 32'(out_rsp.fwd_last), 32'(want.fwd_last));
        fwd_cnt += want.fwd_valid;
        done_cnt += want.done_accepted;
        mem_cnt += want.mem_accepted;
      end
      result_cnt++;
    end
    if (rst_n && in_valid && in_ready) begin
      gate_result_q.push_back(gate_decide(in_req));
      accepted_cnt++;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, gate_result_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through every phase of the gate
    add_fixed(0, 0, 0, 0, 0, 0, 0, 0);  // nothing offered
    add_fixed(0, 0, 0, 0, 1, 1, 1, 1);  // skippable, all-ones payload
    add_fixed(0, 0, 0, 0, 1, 0, 1, 0);  // skippable, not forwarded
    add_fixed(0, 1, 0, 1, 0, 0, 0, 0);  // done with permit, no B needed
    add_fixed(0, 0, 0, 0, 1, 1, 1, 0);  // skippable while ready
    add_fixed(0, 0, 0, 0, 1, 1, 0, 1);  // permitted transfer released
    add_fixed(0, 1, 1, 1, 0, 0, 0, 0);  // done waits for a B
    add_fixed(0, 0, 0, 0, 1, 1, 1, 1);  // skippable while waiting for B
    add_fixed(1, 0, 0, 0, 0, 0, 0, 0);  // B arrives, permit armed
    add_fixed(0, 0, 0, 0, 1, 1, 0, 0);  // release
    add_fixed(0, 1, 0, 0, 1, 1, 0, 1);  // done and transfer together in idle
    add_fixed(0, 0, 0, 0, 1, 1, 0, 1);  // transfer held, waits for done
    add_fixed(0, 1, 1, 1, 0, 0, 0, 0);  // done needs B: both wait
    add_fixed(1, 0, 0, 0, 0, 0, 0, 0);  // late B releases held transfer
    add_fixed(1, 0, 0, 0, 0, 0, 0, 0);  // bank two B beats
    add_fixed(1, 0, 0, 0, 0, 0, 0, 0);
    add_fixed(0, 1, 1, 0, 0, 0, 0, 0);  // spend banked B, no permit
    add_fixed(0, 1, 1, 0, 0, 0, 0, 0);
    add_fixed(0, 1, 1, 1, 0, 0, 0, 0);  // wait for B again
    add_fixed(0, 0, 0, 0, 1, 0, 0, 1);  // held transfer with needs_send low
    add_fixed(1, 0, 0, 0, 0, 0, 0, 0);  // late B, nothing forwarded
    add_fixed(0, 0, 0, 0, 1, 1, 0, 1);  // hold transfer
    add_fixed(0, 1, 0, 0, 0, 0, 0, 0);  // done without permit keeps it held
    add_fixed(0, 1, 1, 0, 0, 0, 0, 0);  // done needs B, no permit
    add_fixed(1, 0, 0, 0, 0, 0, 0, 0);  // B returns to waiting for done
    add_fixed(1, 1, 1, 1, 1, 1, 1, 1);  // done with arriving B releases
    wait_drained();

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_asked++;
    repeat (30) push_scenario();
    wait_drained();

    run_random_phase(0, 0);
    run_random_phase(73, 0);
    run_random_phase(0, 73);
    run_random_phase(32, 32);

    repeat (10) @(posedge clk);
    if (gate_result_q.size() != 0)
      report_mismatch("results never produced", gate_result_q.size(), 32'd0);

    $display("Covered %0d requests (directed walk, input stall under hold-off, four idle mixes)",
             accepted_cnt);
    $display("Checked %0d results: %0d dones, %0d transfers taken, %0d forwarded, %0d errors",
             result_cnt, done_cnt, mem_cnt, fwd_cnt, error_cnt);
    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/wcg_pkg.sv
rtl/wcg_core.sv
rtl/write_completion_gate_unit.sv
tb/write_completion_gate_unit_tb.sv
